@@ rtl/itjg_pkg.sv @@
// Shared types, constants and helpers for the intake toggle jam guard.
`timescale 1ns / 1ps

package itjg_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CfgMinSpeed  = 3'd0;
  localparam logic [2:0] CfgSettleMs  = 3'd1;
  localparam logic [2:0] CfgUnjamMs   = 3'd2;
  localparam logic [2:0] CfgRunPower  = 3'd3;
  localparam logic [2:0] CfgBackPower = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [9:0]  MinSpeedRst  = 10'd55;
  localparam logic [15:0] SettleMsRst  = 16'd100;
  localparam logic [15:0] UnjamMsRst   = 16'd500;
  localparam logic [6:0]  RunPowerRst  = 7'd127;
  localparam logic [6:0]  BackPowerRst = 7'd20;

  // Mode codes as seen on the result port
  localparam logic [1:0] ModeCodeStop = 2'd0;
  localparam logic [1:0] ModeCodeIn   = 2'd1;
  localparam logic [1:0] ModeCodeOut  = 2'd2;
  localparam logic [1:0] ModeCodeJam  = 2'd3;

  typedef enum logic [3:0] {
    MODE_STOP = 4'b0001,
    MODE_IN   = 4'b0010,
    MODE_OUT  = 4'b0100,
    MODE_JAM  = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [9:0]  min_speed;
    logic [15:0] settle_ms;
    logic [15:0] unjam_ms;
    logic [6:0]  run_power;
    logic [6:0]  back_power;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic               pend_in;
    logic [31:0]        start_stamp;
    logic [31:0]        jam_stamp;
    logic signed [7:0]  held_left;
  } state_t;

  typedef struct packed {
    logic               in_press;
    logic               out_press;
    logic signed [10:0] left_speed;
    logic signed [10:0] right_speed;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic [1:0]        mode;
  } result_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    c = ModeCodeStop;
    unique case (m)
      MODE_STOP: c = ModeCodeStop;
      MODE_IN:   c = ModeCodeIn;
      MODE_OUT:  c = ModeCodeOut;
      MODE_JAM:  c = ModeCodeJam;
      default:   c = ModeCodeStop;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/itjg_cfg.sv @@
// Configuration registers of the intake toggle jam guard.
`timescale 1ns / 1ps

module itjg_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [itjg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [itjg_pkg::CfgDataW-1:0]    cfg_data_i,
  output itjg_pkg::cfg_t                   cfg_o
);

  itjg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        itjg_pkg::CfgMinSpeed:  cfg_d.min_speed  = cfg_data_i[9:0];
        itjg_pkg::CfgSettleMs:  cfg_d.settle_ms  = cfg_data_i[15:0];
        itjg_pkg::CfgUnjamMs:   cfg_d.unjam_ms   = cfg_data_i[15:0];
        itjg_pkg::CfgRunPower:  cfg_d.run_power  = cfg_data_i[6:0];
        itjg_pkg::CfgBackPower: cfg_d.back_power = cfg_data_i[6:0];
        default: ; // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed  <= itjg_pkg::MinSpeedRst;
      cfg_q.settle_ms  <= itjg_pkg::SettleMsRst;
      cfg_q.unjam_ms   <= itjg_pkg::UnjamMsRst;
      cfg_q.run_power  <= itjg_pkg::RunPowerRst;
      cfg_q.back_power <= itjg_pkg::BackPowerRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/itjg_core.sv @@
// Per-tick next-state and result logic: toggles, jam check, jam timeout.
`timescale 1ns / 1ps

module itjg_core (
  input  itjg_pkg::cfg_t    cfg_i,
  input  itjg_pkg::state_t  st_i,
  input  itjg_pkg::item_t   item_i,
  output itjg_pkg::state_t  st_o,
  output itjg_pkg::result_t res_o
);

  logic signed [11:0] thr;
  logic signed [11:0] neg_thr;
  logic signed [11:0] left_ext;
  logic signed [11:0] right_ext;
  logic signed [7:0]  run_p;
  logic signed [7:0]  back_p;
  logic [31:0]        run_time;
  logic [31:0]        jam_time;
  itjg_pkg::state_t   s;

  assign thr       = $signed({2'b00, cfg_i.min_speed});
  assign neg_thr   = -thr;
  assign left_ext  = $signed({item_i.left_speed[10], item_i.left_speed});
  assign right_ext = $signed({item_i.right_speed[10], item_i.right_speed});
  assign run_p     = $signed({1'b0, cfg_i.run_power});
  assign back_p    = $signed({1'b0, cfg_i.back_power});

  always_comb begin
    s = st_i;
    run_time = '0;
    jam_time = '0;

    // in request first, then out acts on the resulting mode
    if (st_i.pend_in || item_i.in_press) begin
      if (s.mode != itjg_pkg::MODE_IN) begin
        s.held_left   = run_p;
        s.start_stamp = item_i.now_ms;
        s.mode        = itjg_pkg::MODE_IN;
      end else begin
        s.held_left = '0;
        s.mode      = itjg_pkg::MODE_STOP;
      end
    end
    s.pend_in = 1'b0;

    if (item_i.out_press) begin
      if (s.mode != itjg_pkg::MODE_OUT) begin
        s.held_left   = -run_p;
        s.start_stamp = item_i.now_ms;
        s.mode        = itjg_pkg::MODE_OUT;
      end else begin
        s.held_left = '0;
        s.mode      = itjg_pkg::MODE_STOP;
      end
    end

    run_time = item_i.now_ms - s.start_stamp;
    if (s.mode == itjg_pkg::MODE_IN && run_time > {16'd0, cfg_i.settle_ms}) begin
      if (left_ext < thr || right_ext > neg_thr) begin
        s.held_left = -back_p;
        s.mode      = itjg_pkg::MODE_JAM;
        s.jam_stamp = item_i.now_ms;
      end
    end

    // jam cleared: stop and queue an in request for the next tick
    jam_time = item_i.now_ms - s.jam_stamp;
    if (s.mode == itjg_pkg::MODE_JAM && jam_time > {16'd0, cfg_i.unjam_ms}) begin
      s.pend_in   = 1'b1;
      s.held_left = '0;
      s.mode      = itjg_pkg::MODE_STOP;
    end
  end

  assign st_o              = s;
  assign res_o.left_drive  = s.held_left;
  assign res_o.right_drive = -s.held_left;
  assign res_o.mode        = itjg_pkg::mode_code(s.mode);

endmodule

@@ rtl/intake_toggle_jam_guard_top.sv @@
// Top level of the intake toggle jam guard: input register, tick logic, result register.
`timescale 1ns / 1ps
// Intake toggle jam guard.
// Input channel: one request per control tick (press events, motor speeds,
// millisecond time), moved on in_valid_i && !in_stall_o.
// Output channel: one result per tick (left/right drive, mode), moved on
// out_valid_o && !out_stall_i.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 min_speed, 1 settle_ms, 2 unjam_ms, 3 run_power, 4 back_power);
// write only while no tick is in flight.
// Path: the request sits in the input register, and the tick logic loads the
// result register when the tick advances (result free or not stalled).
// Throughput: one tick per cycle while out_stall_i stays low; the tick logic
// is a few compares and 32-bit subtracts in one pass between the two registers.
// Stall: while the result waits, the input register still takes one more
// request; in_stall_o rises only when both registers are full.
// Reset: mode stopped, held drive zero, no queued press, registers at their
// defaults, both channels empty; the result register is not reset.
module intake_toggle_jam_guard_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [itjg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [itjg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_press_i,
  input  logic                          out_press_i,
  input  logic signed [10:0]            left_speed_i,
  input  logic signed [10:0]            right_speed_i,
  input  logic [31:0]                   now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [7:0]             left_drive_o,
  output logic signed [7:0]             right_drive_o,
  output logic [1:0]                    mode_o
);

  itjg_pkg::cfg_t    cfg;
  itjg_pkg::item_t   item_q;
  itjg_pkg::state_t  st_q, st_d;
  itjg_pkg::result_t res_d, res_q;
  logic              in_vld_q, in_vld_d;
  logic              out_vld_q, out_vld_d;
  logic              advance;
  logic              in_take;

  itjg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  itjg_core u_core (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q          <= 1'b0;
      out_vld_q         <= 1'b0;
      st_q.mode         <= itjg_pkg::MODE_STOP;
      st_q.pend_in      <= 1'b0;
      st_q.start_stamp  <= '0;
      st_q.jam_stamp    <= '0;
      st_q.held_left    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.in_press    <= in_press_i;
      item_q.out_press   <= out_press_i;
      item_q.left_speed  <= left_speed_i;
      item_q.right_speed <= right_speed_i;
      item_q.now_ms      <= now_ms_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign left_drive_o  = res_q.left_drive;
  assign right_drive_o = res_q.right_drive;
  assign mode_o        = res_q.mode;

  // queued in request only follows a jam timeout, which leaves the intake stopped
  a_pend_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pend_in |-> st_q.mode == itjg_pkg::MODE_STOP)
    else $error("queued in request while not stopped");

  a_right_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_drive_o == -left_drive_o)
    else $error("right drive is not the negation of left");

  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("tick advanced but no result shown");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule
